// ===== rtl/core/pcre_pkg.sv =====
// shared types, constants and sha-256 helper functions for the pcr extend engine
// no dependencies
`timescale 1ns / 1ps
package pcre_pkg;
    localparam int REG_COUNT_DEF = 4;
    localparam int LOG_DEPTH_DEF = 64;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ROUND, ST_PAD, ST_LEN, ST_FINISH, ST_XA, ST_XB,
        ST_PCRLOAD, ST_PCRSTORE, ST_EMIT
    } state_t;

    typedef logic [31:0] word_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t init_h(input logic [2:0] i);
        case (i)
            3'd0: init_h = 32'h6a09e667;
            3'd1: init_h = 32'hbb67ae85;
            3'd2: init_h = 32'h3c6ef372;
            3'd3: init_h = 32'ha54ff53a;
            3'd4: init_h = 32'h510e527f;
            3'd5: init_h = 32'h9b05688c;
            3'd6: init_h = 32'h1f83d9ab;
            default: init_h = 32'h5be0cd19;
        endcase
    endfunction

    // all eight initial hash words, word 0 in the top bits
    function automatic logic [255:0] iv_all();
        iv_all = {init_h(3'd0), init_h(3'd1), init_h(3'd2), init_h(3'd3),
                  init_h(3'd4), init_h(3'd5), init_h(3'd6), init_h(3'd7)};
    endfunction

    function automatic word_t round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        round_k = k[i];
    endfunction
endpackage

// ===== rtl/core/pcre_if.sv =====
// valid/ready channel interfaces for the pcr extend engine
// no dependencies
`timescale 1ns / 1ps
interface pcre_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  pcr_select;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;
    modport source (output valid, pcr_select, data_word, byte_count, last, input ready);
    modport sink (input valid, pcr_select, data_word, byte_count, last, output ready);
endinterface

interface pcre_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  word_index;
    logic [63:0] value_word;
    logic        logged;
    logic [5:0]  log_index;
    logic        last_result;
    modport source (output valid, kind, word_index, value_word, logged, log_index,
                    last_result, input ready);
    modport sink (input valid, kind, word_index, value_word, logged, log_index,
                  last_result, output ready);
endinterface

// ===== rtl/core/pcre_ram.sv =====
// generic single-port-write, one-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module pcre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/pcre_core.sv =====
// sha-256 compression core: one round per cycle with rolling 16-word schedule
// depends on pcre_pkg
`timescale 1ns / 1ps
module pcre_core
    import pcre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [511:0] blk,
    input  logic [255:0] h_in,
    output logic        done,
    output logic [255:0] h_out
);
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [255:0] h_reg;
    logic [5:0]  rnd_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] t1, t2, s0, s1, wn;

    always_comb
    begin
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(rnd_reg) + w_reg[0];
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wn = w_reg[0] + s0 + w_reg[9] + s1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            h_reg <= h_in;
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_in[255-32*i -: 32];
            end
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= blk[511-32*i -: 32];
            end
        end
        else if (busy_reg)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wn;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            h_out[255-32*i -: 32] = h_reg[255-32*i -: 32] + v_reg[i];
        end
    end

    assign done = done_reg;
endmodule

// ===== rtl/core/pcr_extend_sha256_top.sv =====
// pcr extend engine top level: input packing, sequencer, pcr bank and log rams
// depends on pcre_pkg, pcre_if, pcre_ram, pcre_core
`timescale 1ns / 1ps
// channel | dir | payload
// in_ch   | in  | pcr_select, data_word, byte_count, last
// out_ch  | out | kind, word_index, value_word, logged, log_index, last_result
// a word is taken while idle; a word that completes a 64-byte block is hashed
// by the one-round-per-cycle core before more are taken. a last word adds one
// or two padding blocks, then, if pcr_select is below REGISTER_COUNT,
// two extend blocks, four-word bank read and write, then eight result transfers
// reset clears the hash state, length, log count and pcr valid bits
// a stalled result holds its payload; no input is taken while results drain
module pcr_extend_sha256_top
    import pcre_pkg::*;
#(
    parameter int REGISTER_COUNT = REG_COUNT_DEF,
    parameter int LOG_DEPTH      = LOG_DEPTH_DEF
) (
    input logic      clk,
    input logic      rst_n,
    pcre_in_if.sink  in_ch,
    pcre_out_if.source out_ch
);
    localparam int PCR_DEPTH = REGISTER_COUNT * 4;
    localparam int PA = (PCR_DEPTH > 1) ? $clog2(PCR_DEPTH) : 1;
    localparam int LD = LOG_DEPTH * 4;
    localparam int LA = (LD > 1) ? $clog2(LD) : 1;
    localparam int RA = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CW = $clog2(LOG_DEPTH + 1);

    state_t       state_reg, state_next;
    logic [511:0] buf_reg;
    logic [255:0] hs_reg, m_reg, r_reg;
    logic [63:0]  len_reg;
    logic [CW-1:0] cnt_reg;
    logic [2:0]   sel_reg;
    logic [2:0]   idx_reg;
    logic         logged_reg;
    logic [RA-1:0] slot_reg;
    logic [PCR_DEPTH-1:0] pvalid_reg;
    logic         core_start;
    logic [511:0] core_blk;
    logic [255:0] core_h;
    logic         core_done;
    logic [255:0] core_out;
    logic         pwe;
    logic [PA-1:0] paddr;
    logic [63:0]  prdata;
    logic [63:0]  pcr_old [3];
    logic [63:0]  pcr_last;
    logic [1:0]   q_reg;
    logic [PA-1:0] pbase;
    logic [LA-1:0] laddr;
    logic [63:0]  spill_reg;
    logic         last_hold_reg;

    // byte packing of one accepted word
    logic [3:0]   nb;
    logic [5:0]   pos;
    logic [511:0] merged;
    logic [6:0]   endpos;
    logic [63:0]  spill;
    always_comb
    begin
        nb = (in_ch.byte_count > 4'd8) ? 4'd8 : in_ch.byte_count;
        pos = len_reg[8:3];
        merged = buf_reg;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < nb && (7'(pos) + 7'(i)) < 7'd64)
            begin
                merged[511 - 8*(pos + 6'(i)) -: 8] = in_ch.data_word[63-8*i -: 8];
            end
        end
        endpos = 7'(pos) + 7'(nb);
        // bytes past the block end, moved to the top for the next block
        spill = in_ch.data_word << {6'd0 - pos, 3'b000};
    end

    // padding block for the final message bytes
    logic [511:0] padblk;
    logic [511:0] lenblk;
    always_comb
    begin
        padblk = buf_reg;
        for (int i = 0; i < 64; i++)
        begin
            if (6'(i) == pos)
            begin
                padblk[511-8*i -: 8] = 8'h80;
            end
            else if (6'(i) > pos)
            begin
                padblk[511-8*i -: 8] = 8'h00;
            end
        end
        lenblk = '0;
        if (pos < 6'd56)
        begin
            padblk[63:0] = len_reg;
        end
        lenblk[63:0] = len_reg;
    end

    assign pbase = PA'(sel_reg) << 2;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign pcr_last = pvalid_reg[pbase + PA'(2'd3)] ? prdata : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            hs_reg     <= iv_all();
            m_reg      <= '0;
            r_reg      <= '0;
            len_reg    <= '0;
            cnt_reg    <= '0;
            pvalid_reg <= '0;
            idx_reg    <= '0;
            q_reg      <= '0;
            logged_reg <= 1'b0;
            slot_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        len_reg <= len_reg + {57'd0, nb, 3'd0};
                    end
                end
                ST_ROUND, ST_PAD, ST_LEN:
                begin
                    if (core_done)
                    begin
                        hs_reg <= core_out;
                    end
                end
                ST_FINISH:
                begin
                    m_reg  <= hs_reg;
                    hs_reg <= iv_all();
                    len_reg <= '0;
                    q_reg  <= '0;
                end
                ST_PCRLOAD:
                begin
                    q_reg <= q_reg + 2'd1;
                end
                ST_XA:
                begin
                    if (core_done)
                    begin
                        r_reg <= core_out;
                    end
                end
                ST_XB:
                begin
                    if (core_done)
                    begin
                        r_reg <= core_out;
                        q_reg <= '0;
                        logged_reg <= (cnt_reg < CW'(LOG_DEPTH));
                        slot_reg <= RA'(cnt_reg);
                    end
                end
                ST_PCRSTORE:
                begin
                    q_reg <= q_reg + 2'd1;
                    pvalid_reg[pbase + PA'(q_reg)] <= 1'b1;
                    if (q_reg == 2'd3)
                    begin
                        idx_reg <= '0;
                        if (logged_reg)
                        begin
                            cnt_reg <= cnt_reg + CW'(1);
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_ch.ready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_ch.valid)
        begin
            buf_reg   <= merged;
            spill_reg <= spill;
            sel_reg   <= in_ch.pcr_select;
        end
        if (state_reg == ST_ROUND && core_done)
        begin
            buf_reg[511 -: 64] <= spill_reg;
        end
        if (state_reg == ST_PCRLOAD && q_reg != 2'd0)
        begin
            pcr_old[q_reg - 2'd1] <= pvalid_reg[pbase + PA'(q_reg - 2'd1)] ? prdata : 64'd0;
        end
    end

    // start pulses ride on state entry
    logic [1:0] sub_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg <= '0;
        end
        else
        begin
            sub_reg <= (state_next != state_reg) ? 2'd0 : 2'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        core_start = 1'b0;
        core_blk   = buf_reg;
        core_h     = hs_reg;
        pwe        = 1'b0;
        paddr      = pbase + PA'(q_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (endpos >= 7'd64)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (in_ch.last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                core_start = (sub_reg == 2'd0);
                if (core_done)
                begin
                    state_next = last_hold_reg ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD:
            begin
                core_start = (sub_reg == 2'd0);
                core_blk = padblk;
                if (core_done)
                begin
                    state_next = (pos < 6'd56) ? ST_FINISH : ST_LEN;
                end
            end
            ST_LEN:
            begin
                core_start = (sub_reg == 2'd0);
                core_blk = lenblk;
                if (core_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ({1'b0, sel_reg} < 4'(REGISTER_COUNT)) ? ST_PCRLOAD : ST_IDLE;
            end
            ST_PCRLOAD:
            begin
                if (q_reg == 2'd3)
                begin
                    state_next = ST_XA;
                end
            end
            ST_XA:
            begin
                core_start = (sub_reg == 2'd0);
                core_blk = {pcr_old[0], pcr_old[1], pcr_old[2], pcr_last, m_reg};
                core_h = iv_all();
                if (core_done)
                begin
                    state_next = ST_XB;
                end
            end
            ST_XB:
            begin
                core_start = (sub_reg == 2'd0);
                core_blk = {32'h80000000, 448'd0, 32'd512};
                core_h = r_reg;
                if (core_done)
                begin
                    state_next = ST_PCRSTORE;
                end
            end
            ST_PCRSTORE:
            begin
                pwe = 1'b1;
                if (q_reg == 2'd3)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ch.ready && idx_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // in_ch fields stay captured in buf/sel; last is held in a register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_ch.valid)
        begin
            last_hold_reg <= in_ch.last;
        end
    end

    pcre_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (core_start),
        .blk   (core_blk),
        .h_in  (core_h),
        .done  (core_done),
        .h_out (core_out)
    );

    pcre_ram #(.WIDTH(64), .DEPTH(PCR_DEPTH)) u_pcr_ram (
        .clk   (clk),
        .we    (pwe),
        .waddr (paddr),
        .wdata (r_reg[255 - 64*q_reg -: 64]),
        .raddr (paddr),
        .rdata (prdata)
    );

    assign laddr = LA'({slot_reg, 2'b00}) + LA'(q_reg);
    logic [63:0] log_rd;
    logic [1:0]  logr_rd;
    pcre_ram #(.WIDTH(64), .DEPTH(LD)) u_log_digest (
        .clk   (clk),
        .we    (state_reg == ST_PCRSTORE && logged_reg),
        .waddr (laddr),
        .wdata (m_reg[255 - 64*q_reg -: 64]),
        .raddr (laddr),
        .rdata (log_rd)
    );
    pcre_ram #(.WIDTH(2), .DEPTH(LOG_DEPTH)) u_log_reg (
        .clk   (clk),
        .we    (state_reg == ST_PCRSTORE && logged_reg && q_reg == 2'd0),
        .waddr (slot_reg),
        .wdata (sel_reg[1:0]),
        .raddr (slot_reg),
        .rdata (logr_rd)
    );

    assign out_ch.valid       = (state_reg == ST_EMIT);
    assign out_ch.kind        = idx_reg[2];
    assign out_ch.word_index  = idx_reg[1:0];
    assign out_ch.value_word  = idx_reg[2] ? r_reg[255 - 64*idx_reg[1:0] -: 64]
                                           : m_reg[255 - 64*idx_reg[1:0] -: 64];
    assign out_ch.logged      = logged_reg;
    assign out_ch.log_index   = logged_reg ? 6'(slot_reg) : 6'd0;
    assign out_ch.last_result = (idx_reg == 3'd7);
endmodule
